[hdl/leib_pkg.sv]
// ----------------------------------------------------------------------------
// Line edit input buffer package
// Ring geometry, key codes, result layout and pointer helpers shared by the
// line edit input buffer modules.
// ----------------------------------------------------------------------------
package leib_pkg;

    // Ring geometry. Pointers count modulo twice the depth so that a full
    // ring and an empty ring can be told apart.
    localparam int RING_DEPTH = 256;
    localparam int PTR_MOD    = 2 * RING_DEPTH;
    localparam int PTR_W      = $clog2(PTR_MOD);
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int ERASE_W    = $clog2(RING_DEPTH + 1);
    localparam int CHAR_W     = 8;

    // Stream widths. Input tdata carries key_code then chars_already_read;
    // output tdata carries every result field, rounded up to whole bytes.
    localparam int IN_BITS  = CHAR_W + 1;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + CHAR_W + ERASE_W + 1 + 2 + 1 + CHAR_W + 1 + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Operation selector.
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Key codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] KEY_NONE   = 8'h00;
    localparam logic [CHAR_W-1:0] KEY_EOF    = 8'h04;
    localparam logic [CHAR_W-1:0] KEY_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] KEY_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] KEY_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] KEY_CTRL_P = 8'h10;
    localparam logic [CHAR_W-1:0] KEY_CTRL_Q = 8'h11;
    localparam logic [CHAR_W-1:0] KEY_KILL   = 8'h15;
    localparam logic [CHAR_W-1:0] KEY_DEL    = 8'h7F;

    // Service request codes.
    localparam logic [1:0] SVC_NONE  = 2'd0;
    localparam logic [1:0] SVC_CLEAR = 2'd1;
    localparam logic [1:0] SVC_MEM   = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    // One result item.
    typedef struct packed {
        logic              read_empty;
        logic              read_eof;
        logic [CHAR_W-1:0] read_char;
        logic              read_valid;
        logic [1:0]        service;
        logic              commit;
        logic [ERASE_W-1:0] erase_count;
        logic [CHAR_W-1:0] echo_char;
        logic              echo_valid;
    } t_result;

    // Ring memory access from the controller.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

    // Pointer step forward, wrapping at twice the depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PTR_MOD - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Pointer step back, wrapping at twice the depth.
    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(PTR_MOD - 1) : p - PTR_W'(1);
    endfunction

    // Distance from b forward to a.
    function automatic logic [PTR_W-1:0] ptr_diff(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[PTR_W]) begin
            d = d + (PTR_W + 1)'(PTR_MOD);
        end
        return d[PTR_W-1:0];
    endfunction

    // Ring slot of a pointer.
    function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p >= PTR_W'(RING_DEPTH)) ? p - PTR_W'(RING_DEPTH) : p;
        return q[IDX_W-1:0];
    endfunction

endpackage

[hdl/leib_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module leib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/leib_ctrl.sv]
// ----------------------------------------------------------------------------
// Line edit controller
// Holds the read, commit and edit pointers, decodes key and read items and
// drives the ring memory. A read of a committed character waits in a read
// state for the memory data.
// ----------------------------------------------------------------------------
module leib_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [leib_pkg::CHAR_W-1:0] i_key_code,
    input  logic                        i_chars_already_read,
    input  logic                        i_out_free,
    output logic                        o_res_valid,
    output leib_pkg::t_result           o_res,
    output leib_pkg::t_ram_req          o_ram_req,
    input  logic [leib_pkg::CHAR_W-1:0] i_ram_rdata
);
    import leib_pkg::*;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_cm_ptr, n_cm_ptr;
    logic [PTR_W-1:0] r_ed_ptr, n_ed_ptr;
    logic             r_already;
    logic             accept;
    logic [PTR_W-1:0] fill;

    // An item is taken only when idle and the output slot will be free.
    assign o_in_ready = (r_state == S_IDLE) && i_out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign fill       = ptr_diff(r_ed_ptr, r_rd_ptr);

    // Item decode and pointer update.
    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_cm_ptr    = r_cm_ptr;
        n_ed_ptr    = r_ed_ptr;
        o_res       = '0;
        o_res_valid = 1'b0;
        o_ram_req   = '0;
        o_ram_req.waddr = ptr_idx(r_ed_ptr);
        o_ram_req.wdata = i_key_code;
        o_ram_req.raddr = ptr_idx(r_rd_ptr);

        case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_KEY) begin
                    o_res_valid = 1'b1;
                    if (i_key_code == KEY_KILL) begin
                        // Drop the whole uncommitted line.
                        n_ed_ptr          = r_cm_ptr;
                        o_res.erase_count = ERASE_W'(ptr_diff(r_ed_ptr, r_cm_ptr));
                    end else if (i_key_code == KEY_BS || i_key_code == KEY_DEL) begin
                        if (r_ed_ptr != r_cm_ptr) begin
                            n_ed_ptr          = ptr_dec(r_ed_ptr);
                            o_res.erase_count = ERASE_W'(1);
                        end
                    end else if (i_key_code == KEY_CTRL_Q) begin
                        o_res.service = SVC_CLEAR;
                    end else if (i_key_code == KEY_CR) begin
                        o_res.service = SVC_MEM;
                    end else if (i_key_code == KEY_CTRL_P || i_key_code == KEY_NONE) begin
                        o_res = '0;
                    end else if (fill < PTR_W'(RING_DEPTH)) begin
                        // Store and echo; end of line, end of file or a full
                        // ring commits the line.
                        o_ram_req.we     = 1'b1;
                        n_ed_ptr         = ptr_inc(r_ed_ptr);
                        o_res.echo_valid = 1'b1;
                        o_res.echo_char  = i_key_code;
                        if (i_key_code == KEY_NL || i_key_code == KEY_EOF ||
                            fill == PTR_W'(RING_DEPTH - 1)) begin
                            n_cm_ptr     = ptr_inc(r_ed_ptr);
                            o_res.commit = 1'b1;
                        end
                    end
                end else if (accept) begin
                    if (r_rd_ptr == r_cm_ptr) begin
                        o_res_valid      = 1'b1;
                        o_res.read_empty = 1'b1;
                    end else begin
                        o_ram_req.re = 1'b1;
                        n_state      = S_READ;
                    end
                end
            end
            S_READ: begin
                // Ring data for the read pointer is back from the memory.
                o_res_valid = 1'b1;
                n_state     = S_IDLE;
                if (i_ram_rdata == KEY_EOF) begin
                    o_res.read_eof = 1'b1;
                    if (!r_already) begin
                        n_rd_ptr = ptr_inc(r_rd_ptr);
                    end
                end else begin
                    n_rd_ptr         = ptr_inc(r_rd_ptr);
                    o_res.read_valid = 1'b1;
                    o_res.read_char  = i_ram_rdata;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_ptr <= '0;
            r_cm_ptr <= '0;
            r_ed_ptr <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_cm_ptr <= n_cm_ptr;
            r_ed_ptr <= n_ed_ptr;
        end
    end

    // Reader flag kept for the cycle of the memory read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_already <= i_chars_already_read;
        end
    end

    // The ring never holds more than its depth between read and edit pointers.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= PTR_W'(RING_DEPTH))
        else $error("ring fill above depth");

    // The commit pointer lies between the read and edit pointers.
    a_commit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ptr_diff(r_cm_ptr, r_rd_ptr) <= fill)
        else $error("commit pointer outside read..edit");

    // A memory read always completes in the next cycle.
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_IDLE)
        else $error("read state held");

    // The read result lands in a free output slot and never meets a write.
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> i_out_free && !o_ram_req.we)
        else $error("read result without free slot");

    // A committed character is fetched only when something is committed.
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_req.re |-> r_rd_ptr != r_cm_ptr)
        else $error("memory read of empty committed region");

endmodule

[hdl/line_edit_input_buffer_core.sv]
// ----------------------------------------------------------------------------
// Line edit input buffer core
// Canonical line editor on a character ring with an output register.
// ----------------------------------------------------------------------------
// A key item, or a read item with nothing committed, gives its result
// directly; other read items pass through a read state, since the character
// comes from the registered read port of the ring memory. One item is
// worked on at a time, and a new one is taken while a finished result sits
// in the output register, as long as that result is taken in the same cycle.
// Each item gives exactly one result transfer. The ring needs no clearing
// after reset: only committed, hence written, entries are ever read.
module line_edit_input_buffer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // [7:0] key_code, [8] chars_already_read, rest zero
    input  logic [leib_pkg::IN_W-1:0]  i_s_tdata,
    // [0] operation
    input  logic                       i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [0] echo_valid, [8:1] echo_char, [17:9] erase_count, [18] commit,
    // [20:19] service, [21] read_valid, [29:22] read_char, [30] read_eof,
    // [31] read_empty
    output logic [leib_pkg::OUT_W-1:0] o_m_tdata
);
    import leib_pkg::*;

    logic              out_free;
    logic              res_valid;
    t_result           res;
    t_ram_req          ram_req;
    logic [CHAR_W-1:0] ram_rdata;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    assign out_free = !r_out_valid || i_m_tready;

    // Pointer and decode logic.
    leib_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_s_tvalid),
        .o_in_ready          (o_s_tready),
        .i_operation         (i_s_tuser),
        .i_key_code          (i_s_tdata[CHAR_W-1:0]),
        .i_chars_already_read(i_s_tdata[CHAR_W]),
        .i_out_free          (out_free),
        .o_res_valid         (res_valid),
        .o_res               (res),
        .o_ram_req           (ram_req),
        .i_ram_rdata         (ram_rdata)
    );

    // Character ring.
    leib_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_req.we),
        .i_waddr(ram_req.waddr),
        .i_wdata(ram_req.wdata),
        .i_re   (ram_req.re),
        .i_raddr(ram_req.raddr),
        .o_rdata(ram_rdata)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= OUT_W'(res);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
